>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> design/cicd_pkg.sv
// ----------------------------------------------------------------------------
// CIC decimator package
// Widths, register map, defaults and the control word passed along the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cicd_pkg;

	// parameter defaults
	localparam int STAGES_DEF    = 4;
	localparam int MAX_DELAY_DEF = 32;
	localparam int ACC_WIDTH_DEF = 32;
	localparam int IN_WIDTH_DEF  = 16;

	// register fields
	localparam int RATIO_W   = 13;
	localparam int DELAY_W   = 6;
	localparam int PHASE_W   = 12;
	localparam int EDW       = 7;   // effective delay, holds MAX_DELAY up to 64
	localparam int PTR_MAX_W = 6;   // pointer field, covers MAX_DELAY up to 64

	localparam logic [RATIO_W-1:0] RATIO_MAX   = 13'd4096;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 13'd1;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 6'd2;

	// APB map, word index taken from paddr[2]
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_RATIO = 1'b0;
	localparam logic REG_DELAY = 1'b1;

	// output word
	localparam int OUT_W  = 32;
	localparam int OUT_TW = 40;

	typedef struct packed {
		logic                 valid;
		logic                 dec;
		logic [PTR_MAX_W-1:0] ptr;
		logic                 ovf;
	} cicd_ctl_t;

endpackage

`default_nettype wire

>>> design/cicd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cicd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/cicd_integ_cell.sv
// ----------------------------------------------------------------------------
// CIC integrator cell
// One accumulator stage; adds the upstream word once per valid word.
// ----------------------------------------------------------------------------
`default_nettype none

module cicd_integ_cell
	import cicd_pkg::*;
#(
	parameter int ACC_W = ACC_WIDTH_DEF,
	parameter int IN_W  = ACC_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire cicd_ctl_t        in_ctl,
	input  wire logic [IN_W-1:0]  in_data,
	output cicd_ctl_t             out_ctl,
	output logic      [ACC_W-1:0] out_data
);

	localparam int SW = ((ACC_W > IN_W) ? ACC_W : IN_W) + 1;

	logic [ACC_W-1:0] acc_q;
	cicd_ctl_t        ctl_q;
	logic [SW-1:0]    sum_full;
	logic             sum_ovf;

	assign sum_full = SW'($signed(acc_q)) + SW'($signed(in_data));
	// true sum must survive a round trip through the accumulator width
	assign sum_ovf  = sum_full != SW'($signed(sum_full[ACC_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= '{valid: in_ctl.valid,
			           dec:   in_ctl.dec,
			           ptr:   in_ctl.ptr,
			           ovf:   in_ctl.ovf | (in_ctl.valid & sum_ovf)};
			if (in_ctl.valid) begin
				acc_q <= sum_full[ACC_W-1:0];
			end
		end
	end

	assign out_ctl  = ctl_q;
	assign out_data = acc_q;

endmodule

`default_nettype wire

>>> design/cicd_comb_cell.sv
// ----------------------------------------------------------------------------
// CIC comb cell
// Differential stage with its own delay RAM, read ahead through the lookahead pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module cicd_comb_cell
	import cicd_pkg::*;
#(
	parameter int ACC_W     = ACC_WIDTH_DEF,
	parameter int MAX_DELAY = MAX_DELAY_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire cicd_ctl_t            in_ctl,
	input  wire logic [ACC_W-1:0]     in_data,
	input  wire logic [PTR_MAX_W-1:0] la_ptr,
	output cicd_ctl_t                 out_ctl,
	output logic      [ACC_W-1:0]     out_data
);

	localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int DW = ACC_W + 1;

	cicd_ctl_t          ctl_q;
	logic [ACC_W-1:0]   data_s1;
	logic [MAX_DELAY-1:0] vld_q;
	logic               vld_rd_q;
	logic               byp_q;
	logic [ACC_W-1:0]   byp_data_q;
	logic [ACC_W-1:0]   ram_rd;
	logic [ACC_W-1:0]   old_val;
	logic [DW-1:0]      diff_full;
	logic               diff_ovf;
	logic               we;
	logic [AW-1:0]      wa;
	logic [AW-1:0]      ra;

	assign we = adv & in_ctl.valid & in_ctl.dec;
	assign wa = in_ctl.ptr[AW-1:0];
	// lookahead address belongs to the word that lands here on the next advance
	assign ra = la_ptr[AW-1:0];

	cicd_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_DELAY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wa),
		.wdata (in_data),
		.re    (adv),
		.raddr (ra),
		.rdata (ram_rd)
	);

	// write of the previous word to the same slot wins over stale RAM data
	assign old_val   = byp_q ? byp_data_q : (vld_rd_q ? ram_rd : '0);
	assign diff_full = DW'($signed(in_data)) - DW'($signed(old_val));
	assign diff_ovf  = diff_full != DW'($signed(diff_full[ACC_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= '0;
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
			byp_q    <= 1'b0;
		end else if (adv) begin
			ctl_q    <= '{valid: in_ctl.valid,
			             dec:   in_ctl.dec,
			             ptr:   in_ctl.ptr,
			             ovf:   in_ctl.ovf | (in_ctl.valid & in_ctl.dec & diff_ovf)};
			vld_rd_q <= vld_q[ra];
			byp_q    <= we & (wa == ra);
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byp_data_q <= in_data;
			data_s1    <= (in_ctl.valid & in_ctl.dec) ? diff_full[ACC_W-1:0] : in_data;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_data = data_s1;

endmodule

`default_nettype wire

>>> design/cic_decimation_filter_unit.sv
// An accepted word passes the input register, every cell register and the output register.
// Throughput: one sample per cycle while not stalled; integrator and comb cells each form one
//   pipeline stage, and the comb delay RAMs are read one stage ahead.
// The whole pipeline stalls only while an output word waits on m_tready.
// Reset (arst_n low): integrators, comb delay slots, pointer, phase and held
//   output clear at once; decim_ratio=1, diff_delay=2. No clearing pass.
// ----------------------------------------------------------------------------
// CIC decimation filter unit
// Hogenauer decimator: integrator cell chain, comb cell chain, held output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cic_decimation_filter_unit
	import cicd_pkg::*;
#(
	parameter int STAGES    = STAGES_DEF,
	parameter int MAX_DELAY = MAX_DELAY_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF,
	parameter int IN_WIDTH  = IN_WIDTH_DEF,
	localparam int IN_TW = ((IN_WIDTH + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input stream
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [IN_TW-1:0]   s_tdata,   // [IN_WIDTH-1:0] sample_in
	// output stream
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [OUT_TW-1:0]  m_tdata,   // [31:0] filter_out, [32] decimated,
	                                           // [33] overflow, rest zero
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

	logic [RATIO_W-1:0] ratio_q;
	logic [DELAY_W-1:0] delay_q;
	logic [RATIO_W-1:0] ratio_eff;
	logic [EDW-1:0]     delay_eff;
	logic               cfg_wr;

	logic               adv;
	logic               acc_w;
	logic               dec_w;
	logic [PHASE_W-1:0] phase_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [PTR_W-1:0]   ptr_eff;
	logic [PTR_W-1:0]   ptr_nxt;
	logic [RATIO_W-1:0] phase_inc;
	logic [EDW-1:0]     ptr_inc;

	cicd_ctl_t          ctl_s0;
	logic [IN_WIDTH-1:0] sample_s0;

	cicd_ctl_t          chain_ctl  [2*STAGES+1];
	logic [ACC_WIDTH-1:0] chain_data [2*STAGES];

	logic               out_vld_q;
	logic               out_dec_q;
	logic               out_ovf_q;
	logic [OUT_W-1:0]   held_q;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
			delay_q <= DELAY_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RATIO: ratio_q <= pwdata[RATIO_W-1:0];
				REG_DELAY: delay_q <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RATIO: prdata = PDATA_W'(ratio_q);
			REG_DELAY: prdata = PDATA_W'(delay_q);
			default:   prdata = '0;
		endcase
	end

	assign ratio_eff = (ratio_q == '0) ? RATIO_W'(1) :
	                   (ratio_q > RATIO_MAX) ? RATIO_MAX : ratio_q;
	assign delay_eff = (delay_q == '0) ? EDW'(1) :
	                   (EDW'(delay_q) > EDW'(MAX_DELAY)) ? EDW'(MAX_DELAY) : EDW'(delay_q);

	// ---------------- front end ----------------
	assign adv      = ~out_vld_q | m_tready;
	assign s_tready = adv;
	assign acc_w    = s_tvalid & s_tready;
	assign dec_w    = (phase_q == '0);

	assign phase_inc = RATIO_W'(phase_q) + RATIO_W'(1);
	assign ptr_eff   = (EDW'(ptr_q) >= delay_eff) ? '0 : ptr_q;
	assign ptr_inc   = EDW'(ptr_eff) + EDW'(1);
	assign ptr_nxt   = (ptr_inc >= delay_eff) ? '0 : ptr_inc[PTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			ptr_q   <= '0;
			ctl_s0  <= '0;
		end else begin
			if (adv) begin
				ctl_s0 <= '{valid: s_tvalid,
				            dec:   dec_w,
				            ptr:   PTR_MAX_W'(ptr_eff),
				            ovf:   1'b0};
			end
			if (acc_w) begin
				phase_q <= (phase_inc >= ratio_eff) ? '0 : phase_inc[PHASE_W-1:0];
				if (dec_w) begin
					ptr_q <= ptr_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_w) begin
			sample_s0 <= s_tdata[IN_WIDTH-1:0];
		end
	end

	assign chain_ctl[0] = ctl_s0;

	// ---------------- cell chains ----------------
	for (genvar j = 0; j < STAGES; j++) begin : g_integ
		if (j == 0) begin : g_first
			cicd_integ_cell #(
				.ACC_W (ACC_WIDTH),
				.IN_W  (IN_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.in_ctl   (chain_ctl[0]),
				.in_data  (sample_s0),
				.out_ctl  (chain_ctl[1]),
				.out_data (chain_data[0])
			);
		end else begin : g_rest
			cicd_integ_cell #(
				.ACC_W (ACC_WIDTH),
				.IN_W  (ACC_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.in_ctl   (chain_ctl[j]),
				.in_data  (chain_data[j-1]),
				.out_ctl  (chain_ctl[j+1]),
				.out_data (chain_data[j])
			);
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_comb
		cicd_comb_cell #(
			.ACC_W     (ACC_WIDTH),
			.MAX_DELAY (MAX_DELAY)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_ctl   (chain_ctl[STAGES+k]),
			.in_data  (chain_data[STAGES+k-1]),
			.la_ptr   (chain_ctl[STAGES+k-1].ptr),
			.out_ctl  (chain_ctl[STAGES+k+1]),
			.out_data (chain_data[STAGES+k])
		);
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_dec_q <= 1'b0;
			out_ovf_q <= 1'b0;
			held_q    <= '0;
		end else if (adv) begin
			out_vld_q <= chain_ctl[2*STAGES].valid;
			if (chain_ctl[2*STAGES].valid) begin
				out_dec_q <= chain_ctl[2*STAGES].dec;
				out_ovf_q <= chain_ctl[2*STAGES].ovf;
				if (chain_ctl[2*STAGES].dec) begin
					held_q <= OUT_W'($signed(chain_data[2*STAGES-1]));
				end
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_TW-OUT_W-2){1'b0}}, out_ovf_q, out_dec_q, held_q};

	// ---------------- checks ----------------
	`ASSERT_CLK(a_ptr_range, (acc_w && dec_w) |=> (EDW'(ptr_q) < $past(delay_eff)), "comb pointer left delay range")
	`ASSERT_CLK(a_ratio_one, (acc_w && ratio_eff == RATIO_W'(1)) |=> (phase_q == '0), "phase moved at ratio one")
	`ASSERT_CLK(a_held_stall, (out_vld_q && !m_tready) |=> $stable(held_q), "held output changed while stalled")
	`ASSERT_NEVER(a_dec_head, acc_w && dec_w && (phase_q != '0), "decimation off phase zero")

endmodule

`default_nettype wire
